@@ sv/rled_pkg.sv @@
`timescale 1ns / 1ps

package rled_pkg;

	localparam int ADDR_BITS_DEF = 16;
	localparam logic [7:0] ESC_BYTE = 8'hED;
	localparam logic [15:0] START_RESET = 16'h4000;

	localparam int QDEPTH = 4;
	localparam int QPTR_BITS = 2;
	localparam int QCNT_BITS = 3;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_ONE_ESC,
		PH_TWO_ESC,
		PH_COUNT
	} phase_t;

	typedef struct packed {
		logic [15:0] addr;
		logic [7:0]  value;
		logic [7:0]  len;
	} run_t;

	// One queue entry: the runs caused by one input byte.
	typedef struct packed {
		logic two;
		logic eos;
		run_t run1;
		run_t run0;
	} entry_t;

endpackage

@@ sv/escape_pair_rle_decoder.sv @@
`timescale 1ns / 1ps
// channel   dir  tdata                                     tuser          tlast
// s_        in   [7:0] stream_byte                         -              last_byte
// m_        out  [15:0] run_address [23:16] run_value      last_of_item   end_of_stream
//                [31:24] run_length
// cfg_      in   cfg_wdata = start_address on cfg_we       -              -
//
// One byte per cycle enters while the queue has room; results leave one beat per
// cycle while m_tready takes them, so a byte that gives two runs leaves as two beats.
// A result reaches m_tvalid through the queue and then the output register: the byte is
// written to the 4-entry queue and the output register loads it once it is free.
// s_tready drops only while the queue is full, i.e. when the output stalls.
// arst_n clears the queue and starts a stream at address 0x4000.

module escape_pair_rle_decoder #(
	parameter int ADDR_BITS = rled_pkg::ADDR_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] stream_byte
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [15:0] run_address, [23:16] run_value, [31:24] run_length
	output logic        m_tuser,   // [0] last_of_item
	output logic        m_tlast
);

	rled_pkg::entry_t wr_entry, rd_entry;
	logic             q_push, q_pop, q_full, q_valid;

	rled_front #(
		.ADDR_BITS(ADDR_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_entry   (wr_entry)
	);

	rled_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_entry (wr_entry),
		.pop      (q_pop),
		.rd_entry (rd_entry),
		.valid    (q_valid),
		.full     (q_full)
	);

	rled_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_entry  (rd_entry),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("queue push while full");

	a_eos_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser)
		else $error("end of stream beat not last of item");

	a_empty_only_marker: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[31:24] == 8'd0) |-> m_tlast && m_tuser)
		else $error("zero length run that is not an end marker");

	a_pop_needs_entry: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue pop while empty");
`endif

endmodule

@@ sv/rled_front.sv @@
`timescale 1ns / 1ps

module rled_front #(
	parameter int ADDR_BITS = rled_pkg::ADDR_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [15:0]       cfg_wdata,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,
	input  logic              s_tlast,
	input  logic              q_full,
	output logic              q_push,
	output rled_pkg::entry_t  q_entry
);

	localparam int AW = ADDR_BITS;
	localparam logic [AW:0] TOP_P1 = (AW + 1)'(1) << AW;
	localparam logic [AW+15:0] RST_WIDE = (AW + 16)'(rled_pkg::START_RESET);
	localparam logic [AW:0] NA_RST = {1'b0, RST_WIDE[AW-1:0]};

	rled_pkg::phase_t phase_q, phase_d;
	logic [AW:0]      na_q, na_d, na1, room;
	logic [7:0]       held_q, held_d, len_clip;
	logic [15:0]      start_q;
	logic [AW+15:0]   start_wide, cfg_wide;
	logic [AW:0]      start_m, cfg_m;
	logic [AW+16:0]   na_wide, na1_wide;
	logic             accept;
	logic             r0v, r1v;
	logic [7:0]       v0, l0;

	assign accept = s_tvalid && !q_full;
	assign s_tready = !q_full;

	assign start_wide = {{AW{1'b0}}, start_q};
	assign start_m = {1'b0, start_wide[AW-1:0]};
	assign cfg_wide = {{AW{1'b0}}, cfg_wdata};
	assign cfg_m = {1'b0, cfg_wide[AW-1:0]};

	assign na1 = na_q + (AW + 1)'(1);
	assign room = TOP_P1 - na_q;
	assign len_clip = ({{(AW - 7){1'b0}}, held_q} > room) ? room[7:0] : held_q;
	assign na_wide = {16'b0, na_q};
	assign na1_wide = {16'b0, na1};

	always_comb begin
		phase_d = phase_q;
		held_d = held_q;
		r0v = 1'b0;
		r1v = 1'b0;
		v0 = s_tdata;
		l0 = 8'd1;
		// once past the top, drop everything
		if (!na_q[AW]) begin
			case (phase_q)
				rled_pkg::PH_IDLE: begin
					if (s_tdata == rled_pkg::ESC_BYTE) begin
						if (s_tlast) begin
							r0v = 1'b1;
						end else begin
							phase_d = rled_pkg::PH_ONE_ESC;
						end
					end else begin
						r0v = 1'b1;
					end
				end
				rled_pkg::PH_ONE_ESC: begin
					if (s_tdata == rled_pkg::ESC_BYTE) begin
						phase_d = rled_pkg::PH_TWO_ESC;
					end else begin
						r0v = 1'b1;
						v0 = rled_pkg::ESC_BYTE;
						r1v = !na1[AW];
						phase_d = rled_pkg::PH_IDLE;
					end
				end
				rled_pkg::PH_TWO_ESC: begin
					held_d = s_tdata;
					phase_d = rled_pkg::PH_COUNT;
				end
				default: begin
					r0v = (held_q != 8'd0);
					l0 = len_clip;
					phase_d = rled_pkg::PH_IDLE;
				end
			endcase
		end

		na_d = na_q + (r0v ? {{(AW - 7){1'b0}}, l0} : '0) + (r1v ? (AW + 1)'(1) : '0);
		if (s_tlast) begin
			phase_d = rled_pkg::PH_IDLE;
			held_d = 8'd0;
			na_d = start_m;
		end

		q_push = accept && (r0v || s_tlast);
		q_entry.two = r1v;
		q_entry.eos = s_tlast;
		q_entry.run0.addr = r0v ? na_wide[15:0] : 16'd0;
		q_entry.run0.value = r0v ? v0 : 8'd0;
		q_entry.run0.len = r0v ? l0 : 8'd0;
		q_entry.run1.addr = na1_wide[15:0];
		q_entry.run1.value = s_tdata;
		q_entry.run1.len = 8'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= rled_pkg::PH_IDLE;
			na_q <= NA_RST;
			held_q <= 8'd0;
			start_q <= rled_pkg::START_RESET;
		end else if (cfg_we) begin
			start_q <= cfg_wdata;
			phase_q <= rled_pkg::PH_IDLE;
			na_q <= cfg_m;
			held_q <= 8'd0;
		end else if (accept) begin
			phase_q <= phase_d;
			na_q <= na_d;
			held_q <= held_d;
		end
	end

endmodule

@@ sv/rled_fifo.sv @@
`timescale 1ns / 1ps

module rled_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  rled_pkg::entry_t  wr_entry,
	input  logic              pop,
	output rled_pkg::entry_t  rd_entry,
	output logic              valid,
	output logic              full
);

	rled_pkg::entry_t                 mem_q [rled_pkg::QDEPTH];
	logic [rled_pkg::QPTR_BITS-1:0]   wr_ptr_q, rd_ptr_q;
	logic [rled_pkg::QCNT_BITS-1:0]   count_q;
	logic                             do_push, do_pop;

	assign valid = (count_q != '0);
	assign full = (count_q == rled_pkg::QCNT_BITS'(rled_pkg::QDEPTH));
	assign do_push = push && !full;
	assign do_pop = pop && valid;
	assign rd_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ sv/rled_back.sv @@
`timescale 1ns / 1ps

module rled_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  rled_pkg::entry_t  q_entry,
	output logic              q_pop,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [31:0]       m_tdata,
	output logic              m_tuser,
	output logic              m_tlast
);

	logic             m_valid_q, sub_q, sub_d;
	logic [31:0]      m_data_q;
	logic             m_user_q, m_last_q;
	logic             load, take, final_beat;
	rled_pkg::run_t   beat;

	assign load = !m_valid_q || m_tready;
	assign take = load && q_valid;
	assign beat = sub_q ? q_entry.run1 : q_entry.run0;
	assign final_beat = sub_q || !q_entry.two;
	assign q_pop = take && final_beat;
	assign sub_d = take ? !final_beat : sub_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
			sub_q <= 1'b0;
		end else begin
			sub_q <= sub_d;
			if (load) begin
				m_valid_q <= q_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			m_data_q <= {beat.len, beat.value, beat.addr};
			m_user_q <= final_beat;
			m_last_q <= final_beat && q_entry.eos;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata = m_data_q;
	assign m_tuser = m_user_q;
	assign m_tlast = m_last_q;

endmodule

@@ tb/escape_pair_rle_decoder_tb.sv @@
`timescale 1ns / 1ps

module escape_pair_rle_decoder_tb;

	localparam logic [16:0] TOP_ADDR = (17'd1 << rled_pkg::ADDR_BITS_DEF) - 17'd1;
	localparam int SETTLE_CYCLES = 4;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		rled_pkg::run_t run;
		logic item_end;
		logic stream_end;
	} run_rec_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = 16'h0000;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;   // [7:0] stream_byte
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;           // [15:0] run_address, [23:16] run_value, [31:24] run_length
	logic        m_tuser;           // [0] last_of_item
	logic        m_tlast;

	// decoder state as predicted
	logic [15:0]       start_addr;
	rled_pkg::phase_t  phase;
	logic [16:0]       nxt_addr;
	logic [7:0]        held_count;

	run_rec_t runs_due[$];
	run_rec_t pend[2];
	int       pend_n;

	int  err_cnt = 0;
	int  runs_checked = 0;
	int  bytes_sent = 0;
	int  streams_sent = 0;
	int  clip_cnt = 0;
	int  dropped_bytes = 0;
	int  hold_left = 0;
	bit  src_idle_on = 1'b0;
	bit  sink_idle_on = 1'b0;

	escape_pair_rle_decoder DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int idle_len();
		if ($urandom_range(0, 4) == 0)
			return $urandom_range(10, 40);
		return $urandom_range(1, 3);
	endfunction

	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		b = 8'($urandom_range(0, 254));
		if (b >= rled_pkg::ESC_BYTE)
			b = b + 8'd1;
		return b;
	endfunction

	function automatic void restart_stream();
		phase = rled_pkg::PH_IDLE;
		nxt_addr = {1'b0, start_addr} & TOP_ADDR;
		held_count = 8'd0;
	endfunction

	// Append one run, cut so that it ends at the top address at most.
	function automatic void add_run(input logic [7:0] value, input logic [7:0] len);
		logic [16:0] room;
		logic [16:0] take;
		if (len == 8'd0 || nxt_addr > TOP_ADDR)
			return;
		room = TOP_ADDR - nxt_addr + 17'd1;
		take = {9'd0, len};
		if (take > room) begin
			take = room;
			clip_cnt++;
		end
		pend[pend_n].run.addr = nxt_addr[15:0];
		pend[pend_n].run.value = value;
		pend[pend_n].run.len = take[7:0];
		pend[pend_n].item_end = 1'b0;
		pend[pend_n].stream_end = 1'b0;
		nxt_addr = nxt_addr + take;
		pend_n++;
	endfunction

	function automatic void decode_byte(input logic [7:0] b, input logic lastb);
		pend_n = 0;
		if (nxt_addr <= TOP_ADDR) begin
			case (phase)
				rled_pkg::PH_IDLE: begin
					if (b != rled_pkg::ESC_BYTE)
						add_run(b, 8'd1);
					else if (lastb)
						add_run(rled_pkg::ESC_BYTE, 8'd1);
					else
						phase = rled_pkg::PH_ONE_ESC;
				end
				rled_pkg::PH_ONE_ESC: begin
					if (b == rled_pkg::ESC_BYTE) begin
						phase = rled_pkg::PH_TWO_ESC;
					end else begin
						add_run(rled_pkg::ESC_BYTE, 8'd1);
						add_run(b, 8'd1);
						phase = rled_pkg::PH_IDLE;
					end
				end
				rled_pkg::PH_TWO_ESC: begin
					held_count = b;
					phase = rled_pkg::PH_COUNT;
				end
				default: begin
					add_run(b, held_count);
					phase = rled_pkg::PH_IDLE;
				end
			endcase
		end else begin
			dropped_bytes++;
		end
		// empty end marker
		if (lastb && pend_n == 0) begin
			pend[0] = '0;
			pend_n = 1;
		end
		if (pend_n > 0) begin
			pend[pend_n - 1].item_end = 1'b1;
			pend[pend_n - 1].stream_end = lastb;
		end
		for (int i = 0; i < pend_n; i++)
			runs_due.push_back(pend[i]);
		if (lastb)
			restart_stream();
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic lastb);
		int gap;
		gap = 0;
		if (src_idle_on && $urandom_range(0, 3) == 0)
			gap = idle_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= lastb;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		decode_byte(b, lastb);
		bytes_sent++;
		if (lastb)
			streams_sent++;
	endtask

	task automatic wait_until_drained();
		s_tvalid <= 1'b0;
		while (runs_due.size() != 0)
			@(posedge clk);
		// bytes that give no run may still be in flight
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_start_address(input logic [15:0] a);
		wait_until_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= a;
		@(posedge clk);
		cfg_we <= 1'b0;
		start_addr = a;
		restart_stream();
	endtask

	task automatic check_beat();
		run_rec_t want;
		run_rec_t got;
		got.run.addr = m_tdata[15:0];
		got.run.value = m_tdata[23:16];
		got.run.len = m_tdata[31:24];
		got.item_end = m_tuser;
		got.stream_end = m_tlast;
		if (runs_due.size() == 0) begin
			err_cnt++;
			if (err_cnt <= MAX_REPORTS)
				$display("%0t: unexpected beat addr=%h val=%h len=%0d ioi=%b eos=%b",
					$realtime, got.run.addr, got.run.value, got.run.len,
					got.item_end, got.stream_end);
			return;
		end
		want = runs_due.pop_front();
		runs_checked++;
		if (got.run.addr != want.run.addr || got.run.value != want.run.value ||
				got.run.len != want.run.len || got.item_end != want.item_end ||
				got.stream_end != want.stream_end) begin
			err_cnt++;
			if (err_cnt <= MAX_REPORTS)
				$display("%0t: mismatch exp addr=%h val=%h len=%0d ioi=%b eos=%b, %s",
					$realtime, want.run.addr, want.run.value, want.run.len,
					want.item_end, want.stream_end,
					$sformatf("got addr=%h val=%h len=%0d ioi=%b eos=%b",
						got.run.addr, got.run.value, got.run.len,
						got.item_end, got.stream_end));
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			check_beat();
	end

	// Output side: long hold-off on request, otherwise random short and long stalls.
	initial begin : sink_side
		int stall;
		stall = 0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else if (stall > 0) begin
				m_tready <= 1'b0;
				stall--;
			end else begin
				m_tready <= 1'b1;
				if (sink_idle_on && $urandom_range(0, 3) == 0)
					stall = idle_len();
			end
		end
	end

	task automatic test_literals_and_escapes();
		src_idle_on = 1'b1;
		sink_idle_on = 1'b1;
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		// lone escape before a plain byte
		send_byte(rled_pkg::ESC_BYTE, 1'b0);
		send_byte(8'h12, 1'b0);
		// zero count writes nothing
		send_byte(rled_pkg::ESC_BYTE, 1'b0);
		send_byte(rled_pkg::ESC_BYTE, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h55, 1'b0);
		send_byte(rled_pkg::ESC_BYTE, 1'b0);
		send_byte(rled_pkg::ESC_BYTE, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hAA, 1'b0);
		send_byte(8'h7E, 1'b1);
	endtask

	task automatic test_stream_end_cases();
		send_byte(rled_pkg::ESC_BYTE, 1'b1);
		send_byte(rled_pkg::ESC_BYTE, 1'b0);
		send_byte(rled_pkg::ESC_BYTE, 1'b1);
		send_byte(rled_pkg::ESC_BYTE, 1'b0);
		send_byte(rled_pkg::ESC_BYTE, 1'b0);
		send_byte(8'h03, 1'b1);
	endtask

	task automatic test_top_of_memory();
		set_start_address(16'hFFFE);
		send_byte(rled_pkg::ESC_BYTE, 1'b0);
		send_byte(rled_pkg::ESC_BYTE, 1'b0);
		send_byte(8'h05, 1'b0);
		send_byte(8'h33, 1'b0);
		// memory full: drop, then only the end marker
		send_byte(8'h44, 1'b0);
		send_byte(8'h01, 1'b1);
		// the pending escape fills the top address, the byte after it is dropped
		set_start_address(16'hFFFF);
		send_byte(rled_pkg::ESC_BYTE, 1'b0);
		send_byte(8'h22, 1'b0);
		send_byte(8'h09, 1'b1);
	endtask

	task automatic test_backpressure();
		set_start_address(16'h1000);
		src_idle_on = 1'b0;
		sink_idle_on = 1'b0;
		hold_left = 150;
		for (int i = 0; i < 12; i++) begin
			send_byte(rled_pkg::ESC_BYTE, 1'b0);
			send_byte(plain_byte(), 1'b0);
		end
		for (int i = 0; i < 10; i++)
			send_byte(plain_byte(), 1'b0);
		// pause with an escape pending until everything is out
		send_byte(rled_pkg::ESC_BYTE, 1'b0);
		send_byte(rled_pkg::ESC_BYTE, 1'b0);
		wait_until_drained();
		send_byte(8'h10, 1'b0);
		send_byte(8'h77, 1'b1);
	endtask

	task automatic send_stream(input bit noisy);
		logic [7:0] bytes_q[$];
		int n_tok;
		int kind;
		int cnt;
		bit ends;
		ends = 1'b1;
		if (noisy) begin
			n_tok = $urandom_range(1, 20);
			for (int i = 0; i < n_tok; i++)
				bytes_q.push_back(($urandom_range(0, 2) == 0) ? rled_pkg::ESC_BYTE :
					8'($urandom_range(0, 255)));
			ends = 1'($urandom_range(0, 1));
		end else begin
			n_tok = $urandom_range(0, 30);
			for (int i = 0; i < n_tok; i++) begin
				kind = $urandom_range(0, 9);
				if (kind < 4) begin
					bytes_q.push_back(plain_byte());
				end else if (kind < 6) begin
					bytes_q.push_back(rled_pkg::ESC_BYTE);
					bytes_q.push_back(plain_byte());
				end else begin
					cnt = $urandom_range(0, 9);
					if (cnt == 0)
						cnt = 0;
					else if (cnt == 1)
						cnt = 255;
					else if (cnt < 4)
						cnt = $urandom_range(1, 4);
					else
						cnt = $urandom_range(1, 255);
					bytes_q.push_back(rled_pkg::ESC_BYTE);
					bytes_q.push_back(rled_pkg::ESC_BYTE);
					bytes_q.push_back(8'(cnt));
					bytes_q.push_back(8'($urandom_range(0, 255)));
				end
			end
			// tail: clean end, lone escape, or an escape cut short
			kind = $urandom_range(0, 5);
			if (kind >= 3)
				bytes_q.push_back(rled_pkg::ESC_BYTE);
			if (kind >= 4)
				bytes_q.push_back(rled_pkg::ESC_BYTE);
			if (kind == 5)
				bytes_q.push_back(8'($urandom_range(0, 255)));
			if (bytes_q.size() == 0)
				bytes_q.push_back(plain_byte());
		end
		foreach (bytes_q[i])
			send_byte(bytes_q[i], ends && (i == bytes_q.size() - 1));
	endtask

	task automatic test_random_streams();
		logic [15:0] starts[8];
		int base;
		starts = '{16'h0000, 16'hFFFF, 16'hFF80, 16'h4000,
			16'hF000, 16'h0000, 16'hFFF0, 16'h0000};
		starts[5] = 16'($urandom_range(0, 65535));
		starts[7] = 16'($urandom_range(16'hE000, 16'hFFFF));
		foreach (starts[p]) begin
			set_start_address(starts[p]);
			src_idle_on = (p % 4) != 1;
			sink_idle_on = (p % 4) != 2;
			base = bytes_sent;
			while (bytes_sent - base < 210)
				send_stream($urandom_range(0, 6) == 0);
		end
	endtask

	initial begin
		#15ms;
		$display("escape_pair_rle_decoder_tb: errors");
		$finish;
	end

	initial begin
		start_addr = rled_pkg::START_RESET;
		restart_stream();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_literals_and_escapes();
		test_stream_end_cases();
		test_top_of_memory();
		test_backpressure();
		test_random_streams();
		wait_until_drained();
		repeat (8) @(posedge clk);
		if (runs_due.size() != 0)
			err_cnt++;
		$display("summary: %0d bytes in %0d streams gave %0d runs, %0d clipped at the top",
			bytes_sent, streams_sent, runs_checked, clip_cnt);
		$display("summary: %0d bytes dropped with memory full, %0d mismatches",
			dropped_bytes, err_cnt);
		if (err_cnt == 0)
			$display("escape_pair_rle_decoder_tb: clean");
		else
			$display("escape_pair_rle_decoder_tb: errors");
		$finish;
	end

endmodule
